// ===== rtl/flheap_pkg.sv =====
// ----------------------------------------------------------------------------
// flheap_pkg
// Shared constants, codes and state type of the first-fit free-list heap
// allocator.
// ----------------------------------------------------------------------------
package flheap_pkg;

  // default geometry of the heap
  localparam int HEAP_UNITS_DEF = 4096;
  localparam int UNIT_BYTES_DEF = 16;

  // field widths of the ports
  localparam int BYTES_W = 16;
  localparam int ADDR_W  = 12;
  localparam int GROW_W  = 13;

  // width of the rounded byte count handed to the divider
  localparam int DIV_W = 17;

  // reset value of the minimum growth register
  localparam logic [GROW_W-1:0] GROW_RESET = 13'd1024;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_OOM  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DISP,
    S_DIV,
    S_TK0,
    S_TK1,
    S_TK2,
    S_TKEX,
    S_TKSP,
    S_TKAG,
    S_GROW,
    S_FR0,
    S_FR1,
    S_FR2,
    S_FR3,
    S_FR4
  } fsm_t;

endpackage

// ===== rtl/free_list_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// free_list_heap_allocator_unit
// First-fit allocator over a circular, address-ordered free list kept in a
// header memory, with arena growth at a break pointer and coalescing on free.
// ----------------------------------------------------------------------------
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+---------------
//  input   | in_action, in_byte_count, in_block_address       | start & !busy
//  result  | out_payload_address, out_status                  | out_valid pulse
//  config  | cfg_min_grow_units                               | cfg_valid/ready
//
//  An allocate passes through dispatch, the unit count by reciprocal
//  multiplication, two reads to reach the first candidate, its check and the
//  result, plus one read of the header memory per free-list header skipped;
//  a growth adds an insertion walk over the free list. A free walks the
//  headers to the insertion point before it links or merges; an ignored free
//  answers from dispatch. The first request also writes the sentinel. Reset is
//  synchronous; the header memory is not cleared. The result strobe lasts one
//  cycle and cannot be stalled; a new start may come in that same cycle.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_unit #(
  parameter int HEAP_UNITS = flheap_pkg::HEAP_UNITS_DEF,
  parameter int UNIT_BYTES = flheap_pkg::UNIT_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_action,
  input  logic [flheap_pkg::BYTES_W-1:0]   in_byte_count,
  input  logic [flheap_pkg::ADDR_W-1:0]    in_block_address,
  output logic                             out_valid,
  output logic [flheap_pkg::ADDR_W-1:0]    out_payload_address,
  output logic                             out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [flheap_pkg::GROW_W-1:0]    cfg_min_grow_units
);

  localparam int AW = $clog2(HEAP_UNITS);
  localparam int SW = AW + 1;
  localparam int NW = flheap_pkg::DIV_W;
  localparam int GW = ((SW > NW) ? SW : NW) + 1;
  localparam int LW = $clog2(UNIT_BYTES);
  localparam int SH = NW + LW;
  localparam int RW = NW + 2;
  localparam int STEP_BOUND = 3 * HEAP_UNITS + 8;
  localparam int SCW = $clog2(STEP_BOUND + 1);

  localparam logic [GW-1:0]   HEAP_G  = GW'(HEAP_UNITS);
  localparam logic [NW-1:0]   UB_M1   = NW'(UNIT_BYTES - 1);
  localparam logic [SCW-1:0]  BOUND_S = SCW'(STEP_BOUND);
  // reciprocal of the unit size, exact for every NW-bit dividend
  localparam logic [RW-1:0]   RECIP   =
    RW'(((64'd1 << SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

  typedef struct packed {
    logic [AW-1:0] next;
    logic [SW-1:0] size;
  } hdr_t;

  // header memory
  hdr_t          mem [HEAP_UNITS];
  hdr_t          rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  hdr_t          mem_wdata;
  logic [AW-1:0] mem_raddr;

  // sequencer and datapath registers
  flheap_pkg::fsm_t state_r, state_nxt;
  logic                          started_r, started_nxt;
  logic [AW-1:0]                 rover_r, rover_nxt;
  logic [SW-1:0]                 brk_r, brk_nxt;
  logic [flheap_pkg::GROW_W-1:0] grow_r;
  logic                          act_r, act_nxt;
  logic [flheap_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [flheap_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [NW-1:0]                 dq_r, dq_nxt;
  logic [NW-1:0]                 nunits_r, nunits_nxt;
  logic [AW-1:0]                 prev_r, prev_nxt;
  logic [AW-1:0]                 p_r, p_nxt;
  logic [AW-1:0]                 cur_next_r, cur_next_nxt;
  logic [AW-1:0]                 bp_r, bp_nxt;
  logic [AW-1:0]                 n_r, n_nxt;
  logic [SW-1:0]                 psize_r, psize_nxt;
  logic [SW-1:0]                 bsz_r, bsz_nxt;
  logic [AW-1:0]                 bnext_r, bnext_nxt;
  logic [SCW-1:0]                tstep_r, tstep_nxt;
  logic [SCW-1:0]                fstep_r, fstep_nxt;
  logic                          from_grow_r, from_grow_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [flheap_pkg::ADDR_W-1:0] out_pay_r, out_pay_nxt;
  logic                          out_status_r, out_status_nxt;

  // shared compare and add terms
  logic [GW-1:0]   d_size_g, nunits_g, grow_g, nu_g, up_nu_g, split_g, split_w_g;
  logic [GW-1:0]   pay_g, addr_g;
  logic [NW+RW-1:0] prod;
  logic            tk_fit, tk_exact, tk_at_rover, tstep_end, fstep_end;
  logic            grow_ovf, fr_hit, fr_merge_hi, fr_merge_lo, free_ok;

  assign d_size_g    = GW'(rd_r.size);
  assign nunits_g    = GW'(nunits_r);
  assign grow_g      = GW'(grow_r);
  assign nu_g        = (nunits_g < grow_g) ? grow_g : nunits_g;
  assign up_nu_g     = GW'(brk_r) + nu_g;
  assign split_g     = GW'(p_r) + d_size_g - nunits_g;
  assign split_w_g   = (split_g >= HEAP_G) ? (split_g - HEAP_G) : split_g;
  assign pay_g       = GW'(p_r) + GW'(1);
  assign addr_g      = GW'(addr_r);
  assign prod        = (NW+RW)'(dq_r) * (NW+RW)'(RECIP);

  assign tk_fit      = d_size_g >= nunits_g;
  assign tk_exact    = d_size_g == nunits_g;
  assign tk_at_rover = p_r == rover_r;
  assign tstep_end   = tstep_r >= BOUND_S;
  assign fstep_end   = fstep_r >= BOUND_S;
  assign grow_ovf    = up_nu_g > HEAP_G;
  assign fr_hit      = (bp_r > p_r && bp_r < rd_r.next) ||
                       (p_r >= rd_r.next && (bp_r > p_r || bp_r < rd_r.next));
  assign fr_merge_hi = (GW'(bp_r) + d_size_g) == GW'(n_r);
  assign fr_merge_lo = (GW'(p_r) + GW'(psize_r)) == GW'(bp_r);
  assign free_ok     = addr_g >= GW'(2) && addr_g < GW'(brk_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flheap_pkg::S_IDLE: if (start) state_nxt = started_r ? flheap_pkg::S_DISP
                                                            : flheap_pkg::S_INIT;
      flheap_pkg::S_INIT: state_nxt = flheap_pkg::S_DISP;
      flheap_pkg::S_DISP: begin
        if (act_r == flheap_pkg::ACT_ALLOC) state_nxt = flheap_pkg::S_DIV;
        else state_nxt = free_ok ? flheap_pkg::S_FR0 : flheap_pkg::S_IDLE;
      end
      flheap_pkg::S_DIV: state_nxt = flheap_pkg::S_TK0;
      flheap_pkg::S_TK0: state_nxt = flheap_pkg::S_TK1;
      flheap_pkg::S_TK1: state_nxt = flheap_pkg::S_TK2;
      flheap_pkg::S_TK2: begin
        priority if (tk_fit) state_nxt = tk_exact ? flheap_pkg::S_TKEX : flheap_pkg::S_TKSP;
        else if (tk_at_rover) state_nxt = flheap_pkg::S_GROW;
        else if (tstep_end) state_nxt = flheap_pkg::S_IDLE;
        else state_nxt = flheap_pkg::S_TK2;
      end
      flheap_pkg::S_TKEX: state_nxt = flheap_pkg::S_IDLE;
      flheap_pkg::S_TKSP: state_nxt = flheap_pkg::S_IDLE;
      flheap_pkg::S_TKAG: state_nxt = tstep_end ? flheap_pkg::S_IDLE : flheap_pkg::S_TK1;
      flheap_pkg::S_GROW: state_nxt = grow_ovf ? flheap_pkg::S_IDLE : flheap_pkg::S_FR0;
      flheap_pkg::S_FR0: state_nxt = flheap_pkg::S_FR1;
      flheap_pkg::S_FR1: begin
        priority if (fr_hit) state_nxt = flheap_pkg::S_FR2;
        else if (fstep_end) state_nxt = flheap_pkg::S_IDLE;
        else state_nxt = flheap_pkg::S_FR1;
      end
      flheap_pkg::S_FR2: state_nxt = fr_merge_hi ? flheap_pkg::S_FR3 : flheap_pkg::S_FR4;
      flheap_pkg::S_FR3: state_nxt = flheap_pkg::S_FR4;
      flheap_pkg::S_FR4: state_nxt = from_grow_r ? flheap_pkg::S_TKAG : flheap_pkg::S_IDLE;
      default: state_nxt = flheap_pkg::S_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    started_nxt    = started_r;
    rover_nxt      = rover_r;
    brk_nxt        = brk_r;
    act_nxt        = act_r;
    bytes_nxt      = bytes_r;
    addr_nxt       = addr_r;
    dq_nxt         = dq_r;
    nunits_nxt     = nunits_r;
    prev_nxt       = prev_r;
    p_nxt          = p_r;
    cur_next_nxt   = cur_next_r;
    bp_nxt         = bp_r;
    n_nxt          = n_r;
    psize_nxt      = psize_r;
    bsz_nxt        = bsz_r;
    bnext_nxt      = bnext_r;
    tstep_nxt      = tstep_r;
    fstep_nxt      = fstep_r;
    from_grow_nxt  = from_grow_r;
    out_valid_nxt  = 1'b0;
    out_pay_nxt    = out_pay_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = p_r;
    mem_wdata      = '0;
    mem_raddr      = p_r;
    unique case (state_r)
      // latch the request
      flheap_pkg::S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          bytes_nxt = in_byte_count;
          addr_nxt  = in_block_address;
        end
      end
      // sentinel on the first request
      flheap_pkg::S_INIT: begin
        mem_we      = 1'b1;
        mem_waddr   = '0;
        mem_wdata   = '0;
        started_nxt = 1'b1;
        rover_nxt   = '0;
      end
      flheap_pkg::S_DISP: begin
        if (act_r == flheap_pkg::ACT_ALLOC) begin
          dq_nxt = NW'(bytes_r) + UB_M1;
        end else if (free_ok) begin
          bp_nxt        = AW'(addr_g - GW'(1));
          from_grow_nxt = 1'b0;
        end else begin
          out_valid_nxt  = 1'b1;
          out_pay_nxt    = '0;
          out_status_nxt = flheap_pkg::ST_DONE;
        end
      end
      // unit count by reciprocal multiplication, plus the header unit
      flheap_pkg::S_DIV: begin
        nunits_nxt = NW'(prod[NW+RW-1:SH]) + NW'(1);
      end
      flheap_pkg::S_TK0: begin
        mem_raddr = rover_r;
        prev_nxt  = rover_r;
        tstep_nxt = '0;
      end
      flheap_pkg::S_TK1: begin
        p_nxt     = rd_r.next;
        mem_raddr = rd_r.next;
      end
      // first-fit check of one block
      flheap_pkg::S_TK2: begin
        cur_next_nxt = rd_r.next;
        priority if (tk_fit) begin
          if (tk_exact) begin
            mem_raddr = prev_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = p_r;
            mem_wdata = '{next: rd_r.next, size: SW'(d_size_g - nunits_g)};
            p_nxt     = AW'(split_w_g);
            mem_raddr = AW'(split_w_g);
          end
        end else if (tk_at_rover) begin
          p_nxt = p_r;
        end else if (tstep_end) begin
          out_valid_nxt  = 1'b1;
          out_pay_nxt    = '0;
          out_status_nxt = flheap_pkg::ST_OOM;
        end else begin
          tstep_nxt = tstep_r + SCW'(1);
          prev_nxt  = p_r;
          p_nxt     = rd_r.next;
          mem_raddr = rd_r.next;
        end
      end
      // unlink an exact fit
      flheap_pkg::S_TKEX: begin
        mem_we         = 1'b1;
        mem_waddr      = prev_r;
        mem_wdata      = '{next: cur_next_r, size: rd_r.size};
        rover_nxt      = prev_r;
        out_valid_nxt  = 1'b1;
        out_pay_nxt    = pay_g[flheap_pkg::ADDR_W-1:0];
        out_status_nxt = flheap_pkg::ST_DONE;
      end
      // header of the split-off tail, its link left as it was
      flheap_pkg::S_TKSP: begin
        mem_we         = 1'b1;
        mem_waddr      = p_r;
        mem_wdata      = '{next: rd_r.next, size: SW'(nunits_g)};
        rover_nxt      = prev_r;
        out_valid_nxt  = 1'b1;
        out_pay_nxt    = pay_g[flheap_pkg::ADDR_W-1:0];
        out_status_nxt = flheap_pkg::ST_DONE;
      end
      // resume the search after growth
      flheap_pkg::S_TKAG: begin
        if (tstep_end) begin
          out_valid_nxt  = 1'b1;
          out_pay_nxt    = '0;
          out_status_nxt = flheap_pkg::ST_OOM;
        end else begin
          tstep_nxt = tstep_r + SCW'(1);
          prev_nxt  = rover_r;
          mem_raddr = rover_r;
        end
      end
      // extend the arena at the break
      flheap_pkg::S_GROW: begin
        if (grow_ovf) begin
          out_valid_nxt  = 1'b1;
          out_pay_nxt    = '0;
          out_status_nxt = flheap_pkg::ST_OOM;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = AW'(brk_r);
          mem_wdata     = '{next: '0, size: SW'(nu_g)};
          brk_nxt       = SW'(up_nu_g);
          bp_nxt        = AW'(brk_r);
          from_grow_nxt = 1'b1;
        end
      end
      flheap_pkg::S_FR0: begin
        mem_raddr = rover_r;
        p_nxt     = rover_r;
        fstep_nxt = '0;
      end
      // walk to the insertion point
      flheap_pkg::S_FR1: begin
        priority if (fr_hit) begin
          n_nxt     = rd_r.next;
          psize_nxt = rd_r.size;
          mem_raddr = bp_r;
        end else if (fstep_end) begin
          out_valid_nxt  = 1'b1;
          out_pay_nxt    = '0;
          out_status_nxt = from_grow_r ? flheap_pkg::ST_OOM : flheap_pkg::ST_DONE;
        end else begin
          fstep_nxt = fstep_r + SCW'(1);
          p_nxt     = rd_r.next;
          mem_raddr = rd_r.next;
        end
      end
      // link or merge with the upper neighbor
      flheap_pkg::S_FR2: begin
        bsz_nxt = rd_r.size;
        if (fr_merge_hi) begin
          mem_raddr = n_r;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = bp_r;
          mem_wdata = '{next: n_r, size: rd_r.size};
          bnext_nxt = n_r;
        end
      end
      flheap_pkg::S_FR3: begin
        mem_we    = 1'b1;
        mem_waddr = bp_r;
        mem_wdata = '{next: rd_r.next, size: bsz_r + rd_r.size};
        bsz_nxt   = bsz_r + rd_r.size;
        bnext_nxt = rd_r.next;
      end
      // link or merge with the lower neighbor
      flheap_pkg::S_FR4: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        if (fr_merge_lo) mem_wdata = '{next: bnext_r, size: psize_r + bsz_r};
        else mem_wdata = '{next: bp_r, size: psize_r};
        rover_nxt = p_r;
        if (!from_grow_r) begin
          out_valid_nxt  = 1'b1;
          out_pay_nxt    = '0;
          out_status_nxt = flheap_pkg::ST_DONE;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // header memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flheap_pkg::S_IDLE;
      started_r   <= 1'b0;
      rover_r     <= '0;
      brk_r       <= SW'(1);
      grow_r      <= flheap_pkg::GROW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      rover_r     <= rover_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) grow_r <= cfg_min_grow_units;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    bytes_r      <= bytes_nxt;
    addr_r       <= addr_nxt;
    dq_r         <= dq_nxt;
    nunits_r     <= nunits_nxt;
    prev_r       <= prev_nxt;
    p_r          <= p_nxt;
    cur_next_r   <= cur_next_nxt;
    bp_r         <= bp_nxt;
    n_r          <= n_nxt;
    psize_r      <= psize_nxt;
    bsz_r        <= bsz_nxt;
    bnext_r      <= bnext_nxt;
    tstep_r      <= tstep_nxt;
    fstep_r      <= fstep_nxt;
    from_grow_r  <= from_grow_nxt;
    out_pay_r    <= out_pay_nxt;
    out_status_r <= out_status_nxt;
  end

  // ports
  assign busy                = state_r != flheap_pkg::S_IDLE;
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_payload_address = out_pay_r;
  assign out_status          = out_status_r;

  // checks
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == flheap_pkg::ST_OOM) |-> out_payload_address == '0)
    else $error("out of memory with nonzero payload");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == flheap_pkg::S_IDLE |-> !mem_we) else $error("header write while idle");

  a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
    GW'(brk_r) <= HEAP_G) else $error("break beyond heap");

endmodule
